@@ rtl/prpi_pkg.sv @@
// ----------------------------------------------------------------------------
// prpi_pkg
// Shared types and codes for the PageRank pull iteration engine.
// ----------------------------------------------------------------------------
package prpi_pkg;

  localparam int unsigned FuncW = 2;
  localparam int unsigned VertW = 10;
  localparam int unsigned DegW  = 16;
  localparam int unsigned InW   = 72;
  localparam int unsigned OutW  = 72;
  localparam int unsigned AddrW = 3;

  // Table depth; a vertex index is the full vertex field.
  localparam int unsigned NumVertices = 1024;

  typedef enum logic [FuncW-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_PULL   = 2'd1,
    FUNC_UPDATE = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  localparam logic [AddrW-1:0] RegDamping = 3'd0;
  localparam logic [AddrW-1:0] RegBase    = 3'd4;

  localparam logic [31:0] DampingReset = 32'd1825361101;

  // Command from the sequencer to the shared datapath unit.
  typedef enum logic [3:0] {
    UOP_MUL = 4'b0001,
    UOP_ADD = 4'b0010,
    UOP_SUB = 4'b0100,
    UOP_DIV = 4'b1000
  } uop_e;

  typedef struct packed {
    logic start;
    uop_e op;
  } ucmd_t;

  typedef struct packed {
    logic done;
    logic clip;
  } ustat_t;

endpackage

@@ rtl/prpi_alu.sv @@
// ----------------------------------------------------------------------------
// prpi_alu
// Shared arithmetic unit: fractional multiply (product shifted down by the
// fraction width, saturating), saturating add, absolute difference and a
// bit-serial restoring divide of 1.0 by a degree.
// ----------------------------------------------------------------------------
module prpi_alu #(
  parameter int unsigned RankBits = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  prpi_pkg::ucmd_t                 cmd_i,
  input  logic [RankBits-1:0]             a_i,
  input  logic [RankBits-1:0]             b_i,
  output prpi_pkg::ustat_t                stat_o,
  output logic [RankBits-1:0]             res_o
);

  localparam int unsigned FracBits = RankBits - 1;
  localparam int unsigned HalfW = (RankBits + 1) / 2;
  localparam int unsigned ProdW = 2 * RankBits;
  localparam int unsigned CntW = $clog2(RankBits + 1);

  logic [ProdW-1:0]    acc_q, acc_d;
  logic [RankBits-1:0] quo_q, quo_d;
  logic [RankBits:0]   rem_q, rem_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                busy_q, busy_d;
  prpi_pkg::uop_e      op_q, op_d;
  logic                done_q, done_d;
  logic                clip_q, clip_d;
  logic [RankBits-1:0] res_q, res_d;

  logic [HalfW-1:0]        a_lo, a_hi;
  logic [HalfW+RankBits-1:0] part;
  logic [RankBits:0]       sum;
  logic [RankBits:0]       rem_sh;
  logic [ProdW-1:0]        prod_sh;

  assign a_lo = HalfW'(a_i);
  assign a_hi = HalfW'(a_i >> HalfW);
  // Multiply runs in two half-width partial products, low half first.
  assign part = (cnt_q == '0 ? a_lo : a_hi) * b_i;
  assign sum = {1'b0, a_i} + {1'b0, b_i};
  // The dividend 1.0 is a single one in the top bit, shifted in first.
  assign rem_sh = {rem_q[RankBits-1:0], (cnt_q == '0)};
  assign prod_sh = acc_q >> FracBits;

  always_comb begin
    acc_d = acc_q;
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    op_d = op_q;
    done_d = 1'b0;
    clip_d = clip_q;
    res_d = res_q;
    if (cmd_i.start) begin
      op_d = cmd_i.op;
      cnt_d = '0;
      acc_d = '0;
      quo_d = '0;
      rem_d = '0;
      case (cmd_i.op)
        prpi_pkg::UOP_ADD: begin
          done_d = 1'b1;
          clip_d = sum[RankBits];
          res_d = sum[RankBits] ? '1 : sum[RankBits-1:0];
        end
        prpi_pkg::UOP_SUB: begin
          done_d = 1'b1;
          clip_d = 1'b0;
          res_d = (a_i >= b_i) ? a_i - b_i : b_i - a_i;
        end
        prpi_pkg::UOP_DIV: begin
          busy_d = 1'b1;
          clip_d = (b_i == '0);
        end
        default: begin
          busy_d = 1'b1;
          clip_d = 1'b0;
        end
      endcase
    end else if (busy_q) begin
      case (op_q)
        prpi_pkg::UOP_MUL: begin
          if (cnt_q == '0) begin
            acc_d = ProdW'(part);
            cnt_d = cnt_q + 1'b1;
          end else begin
            acc_d = acc_q + (ProdW'(part) << HalfW);
            cnt_d = cnt_q + 1'b1;
            if (cnt_q == CntW'(2)) begin
              busy_d = 1'b0;
              done_d = 1'b1;
              acc_d = acc_q;
              clip_d = (prod_sh >> RankBits) != '0;
              res_d = clip_d ? '1 : prod_sh[RankBits-1:0];
            end
          end
        end
        default: begin
          // Restoring divide of 2^FracBits by b, one quotient bit a cycle.
          if (rem_sh >= {1'b0, b_i}) begin
            rem_d = rem_sh - {1'b0, b_i};
            quo_d = {quo_q[RankBits-2:0], 1'b1};
          end else begin
            rem_d = rem_sh;
            quo_d = {quo_q[RankBits-2:0], 1'b0};
          end
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CntW'(RankBits - 1)) begin
            busy_d = 1'b0;
            done_d = 1'b1;
            res_d = clip_q ? '1 : quo_d;
            clip_d = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
      op_q <= prpi_pkg::UOP_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
      op_q <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    clip_q <= clip_d;
    res_q <= res_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.clip = clip_q;
  assign res_o = res_q;

endmodule

@@ rtl/pagerank_pull_iteration_engine.sv @@
// ----------------------------------------------------------------------------
// pagerank_pull_iteration_engine
// PageRank pull engine over per-vertex rank, contribution and sum tables.
// ----------------------------------------------------------------------------
// One item is handled at a time by a sequencer driving one shared arithmetic
// unit; s_axis_tready is low while an item is in work. A pull edge passes
// through table reads, a multiply in two partial products and a saturating
// add, an update through a multiply, an add and an absolute difference, and a
// load through a bit-serial divide producing one quotient bit per cycle. The
// result waits in an output register; the next item is taken once that
// register is free.
// The tables are not cleared at reset: reading a vertex that was never loaded gives
// an arbitrary value.
module pagerank_pull_iteration_engine #(
  parameter int unsigned RANK_BITS    = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: func[1:0], vertex[11:2], neighbor[21:12], has_edge[22],
  // degree[38:23], init_rank[70:39], zero fill[71]
  input  logic [prpi_pkg::InW-1:0]    s_axis_tdata,
  // tlast: last_edge
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tdata: rank_out[31:0], error_out[63:32], zero_degree[64], saturated[65]
  output logic [prpi_pkg::OutW-1:0]   m_axis_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [prpi_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned IdxW = $clog2(prpi_pkg::NumVertices);
  localparam int unsigned RW = RANK_BITS;
  localparam int unsigned CW = (RW < 32) ? RW : 32;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_READ  = 10'b0000000010,
    ST_WAIT  = 10'b0000000100,
    ST_MUL   = 10'b0000001000,
    ST_ADD   = 10'b0000010000,
    ST_ADDW  = 10'b0000100000,
    ST_SUB   = 10'b0001000000,
    ST_SUBW  = 10'b0010000000,
    ST_DIV   = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [RW-1:0] damping_q, base_q, run_q;
  logic [RW-1:0] rank_mem [prpi_pkg::NumVertices];
  logic [RW-1:0] contr_mem [prpi_pkg::NumVertices];
  logic [RW-1:0] sum_mem [prpi_pkg::NumVertices];
  logic [RW-1:0] rank_rd_q, contr_rd_q, sum_rd_q;

  prpi_pkg::func_e func_q;
  logic [IdxW-1:0] vert_q, nb_q;
  logic has_q, last_q;
  logic [prpi_pkg::DegW-1:0] deg_q;
  logic [RW-1:0] init_q;
  logic clip_q, zd_q;
  logic [RW-1:0] rank_o_q, err_o_q;
  logic out_v_q;

  prpi_pkg::ucmd_t cmd;
  prpi_pkg::ustat_t stat;
  logic [RW-1:0] ua, ub, ures;

  logic in_fire, wr_fire;
  logic [IdxW-1:0] in_vert, in_nb;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && !out_v_q;
  assign in_vert = s_axis_tdata[11:2];
  assign in_nb = s_axis_tdata[21:12];

  assign pready = 1'b1;
  assign wr_fire = psel && penable && pwrite;
  always_comb begin
    case (paddr)
      prpi_pkg::RegDamping: prdata = 32'(damping_q);
      prpi_pkg::RegBase:    prdata = 32'(base_q);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damping_q <= RW'(prpi_pkg::DampingReset);
      base_q <= '0;
    end else if (wr_fire) begin
      if (paddr == prpi_pkg::RegDamping) damping_q <= RW'(pwdata[CW-1:0]);
      if (paddr == prpi_pkg::RegBase) base_q <= RW'(pwdata[CW-1:0]);
    end
  end

  prpi_alu #(.RankBits(RW)) u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .a_i   (ua),
    .b_i   (ub),
    .stat_o(stat),
    .res_o (ures)
  );

  // Table reads use the registered index; data appears in ST_WAIT.
  always_ff @(posedge clk_i) begin
    rank_rd_q <= rank_mem[(func_q == prpi_pkg::FUNC_PULL) ? nb_q : vert_q];
    contr_rd_q <= contr_mem[nb_q];
    sum_rd_q <= sum_mem[vert_q];
  end

  always_comb begin
    state_d = state_q;
    cmd.start = 1'b0;
    cmd.op = prpi_pkg::UOP_MUL;
    ua = contr_rd_q;
    ub = rank_rd_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_READ;
      ST_READ: begin
        case (func_q)
          prpi_pkg::FUNC_LOAD: begin
            state_d = ST_DIV;
            cmd.start = 1'b1;
            cmd.op = prpi_pkg::UOP_DIV;
          end
          prpi_pkg::FUNC_PULL:   state_d = has_q ? ST_WAIT : ST_OUT;
          prpi_pkg::FUNC_UPDATE: state_d = ST_WAIT;
          default:               state_d = ST_OUT;
        endcase
        ub = RW'(deg_q);
      end
      ST_WAIT: begin
        state_d = ST_MUL;
        cmd.start = 1'b1;
        if (func_q == prpi_pkg::FUNC_UPDATE) begin
          ua = damping_q;
          ub = sum_rd_q;
        end
      end
      ST_MUL: begin
        // The multiply reads its operands on every step.
        if (func_q == prpi_pkg::FUNC_UPDATE) begin
          ua = damping_q;
          ub = sum_rd_q;
        end
        if (stat.done) state_d = ST_ADD;
      end
      ST_ADD: begin
        state_d = ST_ADDW;
        cmd.start = 1'b1;
        cmd.op = prpi_pkg::UOP_ADD;
        ua = ures;
        ub = (func_q == prpi_pkg::FUNC_UPDATE) ? base_q : run_q;
      end
      ST_ADDW: if (stat.done) state_d = (func_q == prpi_pkg::FUNC_UPDATE) ? ST_SUB : ST_OUT;
      ST_SUB: begin
        state_d = ST_SUBW;
        cmd.start = 1'b1;
        cmd.op = prpi_pkg::UOP_SUB;
        ua = ures;
        ub = rank_rd_q;
      end
      ST_SUBW: if (stat.done) state_d = ST_OUT;
      ST_DIV: begin
        ub = RW'(deg_q);
        if (stat.done) state_d = ST_OUT;
      end
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      run_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (m_axis_tvalid && m_axis_tready) out_v_q <= 1'b0;
      if (state_q == ST_OUT) begin
        out_v_q <= 1'b1;
        if (func_q == prpi_pkg::FUNC_PULL) begin
          if (!has_q || last_q) run_q <= '0;
          else run_q <= rank_o_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= prpi_pkg::func_e'(s_axis_tdata[1:0]);
      vert_q <= in_vert;
      nb_q <= in_nb;
      has_q <= s_axis_tdata[22];
      last_q <= s_axis_tlast;
      deg_q <= s_axis_tdata[38:23];
      init_q <= RW'(s_axis_tdata[70:39]);
      clip_q <= 1'b0;
      zd_q <= 1'b0;
      rank_o_q <= '0;
      err_o_q <= '0;
    end
    if (state_q == ST_READ && func_q == prpi_pkg::FUNC_LOAD) begin
      rank_mem[vert_q] <= init_q;
      zd_q <= (deg_q == '0);
    end
    if (state_q == ST_MUL && stat.done) clip_q <= stat.clip;
    if (state_q == ST_ADDW && stat.done) begin
      clip_q <= clip_q | stat.clip;
      rank_o_q <= ures;
    end
    if (state_q == ST_SUBW && stat.done) err_o_q <= ures;
    if (state_q == ST_DIV && stat.done) contr_mem[vert_q] <= ures;
    if (state_q == ST_OUT) begin
      if (func_q == prpi_pkg::FUNC_PULL && (!has_q || last_q)) sum_mem[vert_q] <= rank_o_q;
      if (func_q == prpi_pkg::FUNC_UPDATE) begin
        sum_mem[vert_q] <= '0;
        rank_mem[vert_q] <= rank_o_q;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {6'd0, clip_q, zd_q, 32'(err_o_q), 32'(rank_o_q)};

endmodule

@@ bench/tb_pagerank_pull_iteration_engine.sv @@
// ----------------------------------------------------------------------------
// tb_pagerank_pull_iteration_engine
// Self-checking bench for the PageRank pull engine. Directed items hit the
// field extremes and the special cases. Random traffic follows, built mostly
// from well-formed load, pull and update sequences. A shadow copy of the
// tables predicts every result field.
// ----------------------------------------------------------------------------
module tb_pagerank_pull_iteration_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] RankMax = 64'hFFFF_FFFF;
  localparam logic [63:0] RankOne = 64'h8000_0000;

  // Packed from the top bit down, so rank_out sits in the lowest bits.
  typedef struct packed {
    logic        saturated;
    logic        zero_degree;
    logic [31:0] error_out;
    logic [31:0] rank_out;
  } rank_res_t;

  class rank_scoreboard;
    logic [31:0] rank_tab [1024];
    logic [31:0] contrib_tab [1024];
    logic [31:0] sum_tab [1024];
    logic [31:0] acc;
    logic [31:0] damping;
    logic [31:0] base_score;
    rank_res_t pending [$];
    int errors;

    function new();
      acc = '0;
      damping = prpi_pkg::DampingReset;
      base_score = '0;
      errors = 0;
    endfunction

    function logic [63:0] qmul(logic [63:0] a, logic [63:0] b, inout bit clip);
      logic [63:0] p;
      p = (a * b) >> 31;
      if (p > RankMax) begin
        clip = 1;
        return RankMax;
      end
      return p;
    endfunction

    function logic [63:0] qadd(logic [63:0] a, logic [63:0] b, inout bit clip);
      logic [63:0] s;
      s = a + b;
      if (s > RankMax) begin
        clip = 1;
        return RankMax;
      end
      return s;
    endfunction

    function void note_item(logic [1:0] fn, logic [9:0] v, logic [9:0] nb, bit he, bit le,
                            logic [15:0] deg, logic [31:0] ir);
      rank_res_t r;
      bit clip;
      logic [63:0] p, nr, old;
      r = '0;
      clip = 0;
      case (fn)
        prpi_pkg::FUNC_LOAD: begin
          rank_tab[v] = ir;
          if (deg == 0) begin
            contrib_tab[v] = RankMax[31:0];
            r.zero_degree = 1;
          end else begin
            contrib_tab[v] = 32'(RankOne / {48'd0, deg});
          end
        end
        prpi_pkg::FUNC_PULL: begin
          if (!he) begin
            sum_tab[v] = '0;
            acc = '0;
          end else begin
            p = qmul({32'd0, contrib_tab[nb]}, {32'd0, rank_tab[nb]}, clip);
            acc = 32'(qadd({32'd0, acc}, p, clip));
            r.rank_out = acc;
            if (le) begin
              sum_tab[v] = acc;
              acc = '0;
            end
          end
        end
        prpi_pkg::FUNC_UPDATE: begin
          old = {32'd0, rank_tab[v]};
          p = qmul({32'd0, damping}, {32'd0, sum_tab[v]}, clip);
          nr = qadd({32'd0, base_score}, p, clip);
          r.error_out = 32'((nr >= old) ? nr - old : old - nr);
          rank_tab[v] = 32'(nr);
          sum_tab[v] = '0;
          r.rank_out = 32'(nr);
        end
        default: ;
      endcase
      r.saturated = clip;
      pending.push_back(r);
    endfunction

    task check_result(rank_res_t got);
      rank_res_t want;
      if (pending.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      want = pending.pop_front();
      if (got.rank_out !== want.rank_out) report("rank_out");
      if (got.error_out !== want.error_out) report("error_out");
      if (got.zero_degree !== want.zero_degree) report("zero_degree");
      if (got.saturated !== want.saturated) report("saturated");
    endtask

    task report(string what);
      errors++;
      if (errors <= 30) $display("mismatch: %s at %0t", what, $time);
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [prpi_pkg::InW-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [prpi_pkg::OutW-1:0] m_axis_tdata;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [prpi_pkg::AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rank_scoreboard sb = new();
  bit loaded [1024];
  bit hold_on = 0;
  bit stall_mode = 0;
  event hold_ev;

  pagerank_pull_iteration_engine DUT (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

  // Long receiver hold-off, counted here once the stimulus asks for it.
  always begin
    @(hold_ev);
    hold_on <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // Receiver: random stall pattern, held off entirely while hold_on is set.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(rank_res_t'(m_axis_tdata[65:0]));
    if (hold_on) begin
      m_axis_tready <= 0;
    end else if (stall_mode) begin
      m_axis_tready <= ($urandom_range(0, 3) == 0);
    end else begin
      m_axis_tready <= ($urandom_range(0, 9) != 0);
    end
  end

  task automatic reg_write(logic [prpi_pkg::AddrW-1:0] a, logic [31:0] d);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (a == prpi_pkg::RegDamping) sb.damping = d;
    else sb.base_score = d;
  endtask

  task automatic send(logic [1:0] fn, logic [9:0] v, logic [9:0] nb, bit he, bit le,
                      logic [15:0] deg, logic [31:0] ir);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {1'b0, ir, deg, he, nb, v, fn};
    s_axis_tlast <= le;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(fn, v, nb, he, le, deg, ir);
    if (fn == prpi_pkg::FUNC_LOAD) loaded[v] = 1;
    if ($urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic [9:0] pick_loaded();
    logic [9:0] n;
    do n = 10'($urandom_range(0, 31)); while (!loaded[n]);
    return n;
  endfunction

  // One well-formed pull run into vertex v over loaded neighbors.
  task automatic pull_run(logic [9:0] v, int n);
    if (n == 0) begin
      send(prpi_pkg::FUNC_PULL, v, 10'($urandom), 1'b0, 1'($urandom), 16'($urandom),
           $urandom);
      return;
    end
    for (int k = 0; k < n; k++)
      send(prpi_pkg::FUNC_PULL, v, pick_loaded(), 1'b1, k == n - 1, 16'($urandom),
           $urandom);
  endtask

  initial begin
    logic [31:0] damp_vals [4];
    logic [31:0] base_vals [4];
    logic [9:0] v;
    damp_vals = '{32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 32'd1825361101};
    base_vals = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1000_0000, 32'h7FFF_FFFF};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: extremes of load fields, zero degree, edgeless vertex,
    // non-last edge, saturation of the sum, update, unused code.
    send(prpi_pkg::FUNC_LOAD, 10'd0, 10'd0, 0, 0, 16'd0, 32'hFFFF_FFFF);
    send(prpi_pkg::FUNC_LOAD, 10'd1023, 10'h3FF, 1, 1, 16'hFFFF, 32'h0);
    send(prpi_pkg::FUNC_LOAD, 10'd1, 10'd0, 0, 0, 16'd1, 32'h8000_0000);
    send(prpi_pkg::FUNC_LOAD, 10'd2, 10'd0, 0, 0, 16'd3, 32'h5555_5555);
    send(prpi_pkg::FUNC_PULL, 10'd1, 10'd0, 1, 0, 16'hFFFF, 32'hFFFF_FFFF);
    send(prpi_pkg::FUNC_PULL, 10'd1, 10'd0, 1, 1, 16'd0, 32'd0);
    send(prpi_pkg::FUNC_PULL, 10'd2, 10'd1023, 1, 0, 16'd0, 32'd0);
    send(prpi_pkg::FUNC_PULL, 10'd2, 10'd1, 1, 1, 16'd0, 32'd0);
    send(prpi_pkg::FUNC_PULL, 10'd1023, 10'd0, 0, 1, 16'd0, 32'd0);
    send(prpi_pkg::FUNC_PULL, 10'd0, 10'h3FF, 0, 0, 16'd0, 32'd0);
    send(prpi_pkg::FUNC_UPDATE, 10'd1, 10'd0, 0, 0, 16'd0, 32'd0);
    send(prpi_pkg::FUNC_UPDATE, 10'd2, 10'h3FF, 1, 1, 16'hFFFF, 32'hFFFF_FFFF);
    send(prpi_pkg::FUNC_UPDATE, 10'd1023, 10'd0, 0, 0, 16'd0, 32'd0);
    send(prpi_pkg::FUNC_UPDATE, 10'd0, 10'd0, 0, 0, 16'd0, 32'd0);
    send(prpi_pkg::FUNC_NONE, 10'h3FF, 10'h3FF, 1, 1, 16'hFFFF, 32'hFFFF_FFFF);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      reg_write(prpi_pkg::RegDamping, damp_vals[ph]);
      reg_write(prpi_pkg::RegBase, base_vals[ph]);
      for (int i = 0; i < 32; i++)
        send(prpi_pkg::FUNC_LOAD, 10'(i), 10'($urandom), 1'($urandom), 1'($urandom),
             ($urandom_range(0, 9) == 0) ? 16'd0 :
               16'($urandom_range(1, 65535) >> $urandom_range(0, 15)),
             $urandom);
      if (ph == 1) begin
        // Long receiver hold-off while items keep coming.
        -> hold_ev;
      end
      stall_mode = (ph == 2);
      for (int r = 0; r < 58; r++) begin
        v = 10'($urandom_range(0, 31));
        case ($urandom_range(0, 9))
          0: send(prpi_pkg::FUNC_NONE, 10'($urandom), 10'($urandom), 1'($urandom),
                  1'($urandom), 16'($urandom), $urandom);
          1: send(prpi_pkg::FUNC_LOAD, v, 10'($urandom), 1'($urandom), 1'($urandom),
                  16'($urandom), $urandom);
          2: pull_run(v, 0);
          default: begin
            pull_run(v, $urandom_range(1, 6));
            send(prpi_pkg::FUNC_UPDATE, v, 10'($urandom), 1'($urandom), 1'($urandom),
                 16'($urandom), $urandom);
          end
        endcase
      end
      drain();
    end
    stall_mode = 0;

    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
